// ----- rtl/rect_pkg.sv -----
// package with codes, types and defaults of the record event collation table
`timescale 1ns / 1ps
package rect_pkg;

  // default depth of the entry table
  localparam int RECT_ENTRIES = 1024;
  localparam int SLOTS        = 5;
  localparam int ENT_W        = 10;
  localparam int HND_W        = 16;

  // command codes
  localparam logic [1:0] MODE_RECORD     = 2'd0;
  localparam logic [1:0] MODE_DISCARD    = 2'd1;
  localparam logic [1:0] MODE_DISTRIBUTE = 2'd2;
  localparam logic [1:0] MODE_UNUSED     = 2'd3;

  // record type codes
  localparam logic [2:0] TYPE_SYSCALL = 3'd0;
  localparam logic [2:0] TYPE_EXECVE  = 3'd1;
  localparam logic [2:0] TYPE_CWD     = 3'd2;
  localparam logic [2:0] TYPE_PATH    = 3'd3;

  // slot codes
  localparam logic [2:0] SLOT_PATH1 = 3'd3;
  localparam logic [2:0] SLOT_PATH2 = 3'd4;

  // status codes
  localparam logic [2:0] ST_HELD        = 3'd0;
  localparam logic [2:0] ST_COMPLETE    = 3'd1;
  localparam logic [2:0] ST_NO_FREE     = 3'd2;
  localparam logic [2:0] ST_REJECTED    = 3'd3;
  localparam logic [2:0] ST_DISCARDED   = 3'd4;
  localparam logic [2:0] ST_DISTRIBUTED = 3'd5;
  localparam logic [2:0] ST_NOT_HELD    = 3'd6;

  // path count before any syscall record
  localparam logic [4:0] COUNT_UNKNOWN = 5'd31;
  localparam logic [4:0] COUNT_ONE     = 5'd1;
  localparam logic [4:0] COUNT_TWO     = 5'd2;

  // per-entry bookkeeping word
  typedef struct packed {
    logic        in_use;
    logic [31:0] key;
    logic [4:0]  full;
    logic [4:0]  cnt;
  } meta_t;

  // all handles of one entry
  typedef logic [SLOTS-1:0][HND_W-1:0] handle_row_t;

  // request to the result sequencer
  typedef struct packed {
    logic [2:0]       st;
    logic [ENT_W-1:0] ent;
    logic [SLOTS-1:0] mask;
    handle_row_t      row;
  } emit_load_t;

endpackage

// ----- rtl/rect_if.sv -----
// valid/ready channel interfaces for records and results
`timescale 1ns / 1ps
interface rect_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] seq_num;
  logic [2:0]  rec_type;
  logic [3:0]  item_count;
  logic [15:0] rec_handle;
  logic [9:0]  entry_sel;

  modport source (output valid, mode, seq_num, rec_type, item_count, rec_handle,
                  entry_sel, input ready);
  modport sink (input valid, mode, seq_num, rec_type, item_count, rec_handle,
                entry_sel, output ready);
endinterface

interface rect_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  held_entry;
  logic [2:0]  slot;
  logic [15:0] handle_out;
  logic        handle_valid;
  logic        final_item;

  modport source (output valid, status, held_entry, slot, handle_out, handle_valid,
                  final_item, input ready);
  modport sink (input valid, status, held_entry, slot, handle_out, handle_valid,
                final_item, output ready);
endinterface

// ----- rtl/rect_free_queue.sv -----
// fifo of free entry indices with its reset fill pass
`timescale 1ns / 1ps
module rect_free_queue import rect_pkg::*; #(
  parameter int ENTRIES = RECT_ENTRIES,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop,
  input  logic          push,
  input  logic [IW-1:0] push_idx,
  output logic [IW-1:0] pop_data,
  output logic          level_zero,
  output logic          clr_active,
  output logic [IW-1:0] clr_idx
);

  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [IW:0]   FULL = (IW + 1)'(ENTRIES);

  logic [IW-1:0] fq_mem [ENTRIES];
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW:0]   level_r, level_nxt;
  logic [IW-1:0] clr_idx_r, clr_idx_nxt;
  logic          clr_active_r, clr_active_nxt;
  logic [IW-1:0] rd_q;

  // pointers, level and fill pass
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    level_nxt      = level_r;
    clr_idx_nxt    = clr_idx_r;
    clr_active_nxt = clr_active_r;
    if (clr_active_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == LAST) clr_active_nxt = 1'b0;
    end
    if (pop) begin
      head_nxt  = (head_r == LAST) ? '0 : head_r + 1'b1;
      level_nxt = level_r - 1'b1;
    end
    if (push) begin
      tail_nxt = (tail_r == LAST) ? '0 : tail_r + 1'b1;
      if (level_r < FULL) level_nxt = level_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      level_r      <= FULL;
      clr_idx_r    <= '0;
      clr_active_r <= 1'b1;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      level_r      <= level_nxt;
      clr_idx_r    <= clr_idx_nxt;
      clr_active_r <= clr_active_nxt;
    end
  end

  // queue memory
  always_ff @(posedge clk) begin
    if (clr_active_r) fq_mem[clr_idx_r] <= clr_idx_r;
    else if (push) fq_mem[tail_r] <= push_idx;
    rd_q <= fq_mem[head_r];
  end

  assign pop_data   = rd_q;
  assign level_zero = (level_r == '0);
  assign clr_active = clr_active_r;
  assign clr_idx    = clr_idx_r;

endmodule

// ----- rtl/rect_emitter.sv -----
// result sequencer: walks the held slots into the output register
`timescale 1ns / 1ps
module rect_emitter import rect_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ld,
  input  emit_load_t ld_data,
  output logic       busy,
  rect_out_if.source out_ch
);

  logic             busy_r, busy_nxt;
  logic [SLOTS-1:0] mask_r, mask_nxt;
  logic             none_r, none_nxt;
  logic [2:0]       st_r;
  logic [ENT_W-1:0] ent_r;
  handle_row_t      row_r;
  logic             ov_r, ov_nxt;
  logic [2:0]       o_st_r, o_st_nxt;
  logic [ENT_W-1:0] o_ent_r, o_ent_nxt;
  logic [2:0]       o_slot_r, o_slot_nxt;
  logic [15:0]      o_h_r, o_h_nxt;
  logic             o_hv_r, o_hv_nxt;
  logic             o_fin_r, o_fin_nxt;
  logic             adv;
  logic [2:0]       pick;
  logic [SLOTS-1:0] rest;

  // lowest held slot
  always_comb begin
    pick = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) pick = 3'(i);
    end
    rest = mask_r & ~(SLOTS'(1) << pick);
  end

  assign adv = busy_r && (!ov_r || out_ch.ready);

  // next beat selection
  always_comb begin
    busy_nxt   = busy_r;
    mask_nxt   = mask_r;
    none_nxt   = none_r;
    ov_nxt     = ov_r && !out_ch.ready;
    o_st_nxt   = o_st_r;
    o_ent_nxt  = o_ent_r;
    o_slot_nxt = o_slot_r;
    o_h_nxt    = o_h_r;
    o_hv_nxt   = o_hv_r;
    o_fin_nxt  = o_fin_r;
    if (adv) begin
      ov_nxt    = 1'b1;
      o_st_nxt  = st_r;
      o_ent_nxt = ent_r;
      if (none_r) begin
        o_slot_nxt = '0;
        o_h_nxt    = '0;
        o_hv_nxt   = 1'b0;
        o_fin_nxt  = 1'b1;
        busy_nxt   = 1'b0;
      end else begin
        o_slot_nxt = pick;
        o_h_nxt    = row_r[pick];
        o_hv_nxt   = 1'b1;
        o_fin_nxt  = (rest == '0);
        busy_nxt   = (rest != '0);
        mask_nxt   = rest;
      end
    end
    if (ld) begin
      busy_nxt = 1'b1;
      mask_nxt = ld_data.mask;
      none_nxt = (ld_data.mask == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mask_r   <= mask_nxt;
    none_r   <= none_nxt;
    o_st_r   <= o_st_nxt;
    o_ent_r  <= o_ent_nxt;
    o_slot_r <= o_slot_nxt;
    o_h_r    <= o_h_nxt;
    o_hv_r   <= o_hv_nxt;
    o_fin_r  <= o_fin_nxt;
    if (ld) begin
      st_r  <= ld_data.st;
      ent_r <= ld_data.ent;
      row_r <= ld_data.row;
    end
  end

  assign busy                = busy_r;
  assign out_ch.valid        = ov_r;
  assign out_ch.status       = o_st_r;
  assign out_ch.held_entry   = o_ent_r;
  assign out_ch.slot         = o_slot_r;
  assign out_ch.handle_out   = o_h_r;
  assign out_ch.handle_valid = o_hv_r;
  assign out_ch.final_item   = o_fin_r;

endmodule

// ----- rtl/record_event_collation_table.sv -----
// top level: entry table memories and the record sequencer
//
//  channel  | dir | beat payload
//  in_ch    | in  | mode, seq_num, rec_type, item_count, rec_handle, entry_sel
//  out_ch   | out | status, held_entry, slot, handle_out, handle_valid, final_item
//
// a record scans the key memory one entry a cycle until a hit or the last entry;
// a miss then takes an entry from the free queue; discard/distribute check entry_sel
// results leave one beat a cycle from the output register while the receiver is ready, up to five a command
// after reset a fill pass over all ENTRIES clears the table and loads every index into the free queue
// a stalled output holds the next command until the last result of the current one is in the output register
`timescale 1ns / 1ps
module record_event_collation_table import rect_pkg::*; #(
  parameter int ENTRIES = RECT_ENTRIES
) (
  input  logic     clk,
  input  logic     rst_n,
  rect_in_if.sink  in_ch,
  rect_out_if.source out_ch
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FQ   = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;

  meta_t       meta_mem [ENTRIES];
  handle_row_t hand_mem [ENTRIES];
  meta_t       meta_q;
  handle_row_t hrow_q;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    mode_r;
  logic [31:0]   key_r;
  logic [2:0]    type_r;
  logic [3:0]    cnt_r;
  logic [15:0]   h_r;
  logic [IW-1:0] e_r, e_nxt;
  logic [4:0]    cur_full_r, cur_full_nxt;
  logic [4:0]    cur_cnt_r, cur_cnt_nxt;
  logic          fresh_r, fresh_nxt;
  logic [IW-1:0] scan_addr_r, scan_addr_nxt;
  logic          issue_r, issue_nxt;
  logic [IW-1:0] rd_addr_r, rd_addr_nxt;
  logic          rd_vld_r, rd_vld_nxt;

  logic          accept;
  logic          em_busy, em_ld;
  emit_load_t    em_data;
  logic          fq_pop, fq_push, fq_zero, clr_active;
  logic [IW-1:0] fq_data, clr_idx;
  logic [IW-1:0] meta_raddr, hand_raddr, meta_waddr;
  logic          meta_we, hand_we;
  meta_t         meta_wdata;
  handle_row_t   hand_wdata;
  logic          sel_ok;
  logic          slot_ok;
  logic [2:0]    s_pick;
  logic [4:0]    s_bit, new_full, new_cnt;
  logic          complete;
  handle_row_t   new_row;
  logic          hit;

  assign in_ch.ready = (state_r == S_IDLE) && !em_busy && !clr_active;
  assign accept      = in_ch.valid && in_ch.ready;
  assign sel_ok      = 32'(in_ch.entry_sel) < 32'(ENTRIES);
  assign hit         = rd_vld_r && meta_q.in_use && (meta_q.key == key_r);

  // slot choice for the current record
  always_comb begin
    slot_ok = 1'b0;
    s_pick  = '0;
    if (type_r == TYPE_SYSCALL || type_r == TYPE_EXECVE || type_r == TYPE_CWD) begin
      slot_ok = !cur_full_r[type_r];
      s_pick  = type_r;
    end else if (type_r == TYPE_PATH) begin
      if (!cur_full_r[SLOT_PATH1]) begin
        slot_ok = 1'b1;
        s_pick  = SLOT_PATH1;
      end else if (!cur_full_r[SLOT_PATH2]) begin
        slot_ok = 1'b1;
        s_pick  = SLOT_PATH2;
      end
    end
    s_bit    = 5'b00001 << s_pick;
    new_full = cur_full_r | s_bit;
    new_cnt  = (type_r == TYPE_SYSCALL) ? {1'b0, cnt_r} : cur_cnt_r;
    new_row  = hrow_q;
    new_row[s_pick] = h_r;
    case (new_cnt)
      COUNT_UNKNOWN: complete = 1'b0;
      COUNT_ONE:     complete = new_full[SLOT_PATH1];
      COUNT_TWO:     complete = new_full[SLOT_PATH1] && new_full[SLOT_PATH2];
      default:       complete = 1'b1;
    endcase
  end

  // record sequencer
  always_comb begin
    state_nxt     = state_r;
    e_nxt         = e_r;
    cur_full_nxt  = cur_full_r;
    cur_cnt_nxt   = cur_cnt_r;
    fresh_nxt     = fresh_r;
    scan_addr_nxt = scan_addr_r;
    issue_nxt     = issue_r;
    rd_addr_nxt   = rd_addr_r;
    rd_vld_nxt    = 1'b0;
    meta_raddr    = scan_addr_r;
    hand_raddr    = rd_addr_r;
    meta_we       = 1'b0;
    meta_waddr    = e_r;
    meta_wdata    = '0;
    hand_we       = 1'b0;
    hand_wdata    = new_row;
    fq_pop        = 1'b0;
    fq_push       = 1'b0;
    em_ld         = 1'b0;
    em_data       = '0;
    em_data.ent   = ENT_W'(e_r);
    case (state_r)
      S_IDLE: begin
        meta_raddr = IW'(in_ch.entry_sel);
        hand_raddr = IW'(in_ch.entry_sel);
        e_nxt      = IW'(in_ch.entry_sel);
        if (accept) begin
          if (in_ch.mode == MODE_RECORD) begin
            state_nxt     = S_SCAN;
            scan_addr_nxt = '0;
            issue_nxt     = 1'b1;
          end else if (in_ch.mode == MODE_DISCARD || in_ch.mode == MODE_DISTRIBUTE) begin
            if (sel_ok) begin
              state_nxt = S_CHK;
            end else begin
              em_ld       = 1'b1;
              em_data.st  = ST_NOT_HELD;
              em_data.ent = in_ch.entry_sel;
            end
          end
        end
      end
      S_SCAN: begin
        if (issue_r) begin
          rd_addr_nxt = scan_addr_r;
          rd_vld_nxt  = 1'b1;
          if (scan_addr_r == LAST) issue_nxt = 1'b0;
          else scan_addr_nxt = scan_addr_r + 1'b1;
        end
        if (hit) begin
          e_nxt        = rd_addr_r;
          cur_full_nxt = meta_q.full;
          cur_cnt_nxt  = meta_q.cnt;
          fresh_nxt    = 1'b0;
          state_nxt    = S_UPD;
        end else if (rd_vld_r && rd_addr_r == LAST) begin
          if (fq_zero) begin
            em_ld       = 1'b1;
            em_data.st  = ST_NO_FREE;
            em_data.ent = '0;
            state_nxt   = S_IDLE;
          end else begin
            fq_pop    = 1'b1;
            state_nxt = S_FQ;
          end
        end
      end
      S_FQ: begin
        e_nxt        = fq_data;
        cur_full_nxt = '0;
        cur_cnt_nxt  = COUNT_UNKNOWN;
        fresh_nxt    = 1'b1;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        em_ld   = 1'b1;
        meta_we = 1'b1;
        if (!slot_ok) begin
          em_data.st   = ST_REJECTED;
          em_data.mask = fresh_r ? 5'd0 : cur_full_r;
          em_data.row  = hrow_q;
          fq_push      = 1'b1;
        end else begin
          meta_wdata.in_use = 1'b1;
          meta_wdata.key    = key_r;
          meta_wdata.full   = new_full;
          meta_wdata.cnt    = new_cnt;
          hand_we           = 1'b1;
          em_data.st        = complete ? ST_COMPLETE : ST_HELD;
          em_data.mask      = complete ? new_full : s_bit;
          em_data.row       = new_row;
        end
        state_nxt = S_IDLE;
      end
      S_CHK: begin
        em_ld = 1'b1;
        if (!meta_q.in_use) begin
          em_data.st = ST_NOT_HELD;
        end else begin
          em_data.st   = (mode_r == MODE_DISCARD) ? ST_DISCARDED : ST_DISTRIBUTED;
          em_data.mask = meta_q.full;
          em_data.row  = hrow_q;
          meta_we      = 1'b1;
          fq_push      = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (clr_active) begin
      meta_we    = 1'b1;
      meta_waddr = clr_idx;
      meta_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issue_r  <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issue_r  <= issue_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // command and working registers
  always_ff @(posedge clk) begin
    e_r         <= e_nxt;
    cur_full_r  <= cur_full_nxt;
    cur_cnt_r   <= cur_cnt_nxt;
    fresh_r     <= fresh_nxt;
    scan_addr_r <= scan_addr_nxt;
    rd_addr_r   <= rd_addr_nxt;
    if (accept) begin
      mode_r <= in_ch.mode;
      key_r  <= in_ch.seq_num;
      type_r <= in_ch.rec_type;
      cnt_r  <= in_ch.item_count;
      h_r    <= in_ch.rec_handle;
    end
  end

  // entry memories
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    meta_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (hand_we) hand_mem[e_r] <= hand_wdata;
    hrow_q <= hand_mem[hand_raddr];
  end

  rect_free_queue #(.ENTRIES(ENTRIES)) u_fq (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop        (fq_pop),
    .push       (fq_push),
    .push_idx   (e_r),
    .pop_data   (fq_data),
    .level_zero (fq_zero),
    .clr_active (clr_active),
    .clr_idx    (clr_idx)
  );

  rect_emitter u_em (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld      (em_ld),
    .ld_data (em_data),
    .busy    (em_busy),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |-> !fq_zero) else $error("pop from empty free queue");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    em_ld |-> !em_busy) else $error("result load while sequencer busy");
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_active |=> !clr_active) else $error("fill pass restarted");
  a_upd_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> ($past(state_r) == S_SCAN || $past(state_r) == S_FQ))
    else $error("update without lookup");
`endif

endmodule

// ----- tb/sv/rect_scoreboard.sv -----
// scoreboard class: collation table predictor and result checker
`timescale 1ns / 1ps
package rect_tb_pkg;
  import rect_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  held_entry;
    logic [2:0]  slot;
    logic [15:0] handle_out;
    logic        handle_valid;
    logic        final_item;
  } result_t;

  class collation_scoreboard;
    bit          in_use [RECT_ENTRIES];
    logic [31:0] key_tab [RECT_ENTRIES];
    logic [4:0]  full_tab [RECT_ENTRIES];
    logic [15:0] hnd_tab [RECT_ENTRIES][SLOTS];
    logic [4:0]  cnt_tab [RECT_ENTRIES];
    int          free_q [$];
    result_t     pending [$];
    int          errors;

    function new();
      for (int i = 0; i < RECT_ENTRIES; i++) begin
        in_use[i] = 0;
        free_q.push_back(i);
      end
      errors = 0;
    endfunction

    function int free_count();
      return free_q.size();
    endfunction

    function void push(logic [2:0] st, int e, int sl, logic [15:0] h, bit v);
      result_t r;
      r.status = st;
      r.held_entry = e[9:0];
      r.slot = sl[2:0];
      r.handle_out = h;
      r.handle_valid = v;
      r.final_item = 0;
      pending.push_back(r);
    endfunction

    // emit every held handle in slot order, or one empty result
    function void emit_held(int e, logic [2:0] st);
      int n;
      n = 0;
      for (int s = 0; s < SLOTS; s++)
        if (full_tab[e][s]) begin
          push(st, e, s, hnd_tab[e][s], 1);
          n++;
        end
      if (n == 0) push(st, e, 0, 0, 0);
    endfunction

    function void release_entry(int e);
      in_use[e] = 0;
      full_tab[e] = 0;
      free_q.push_back(e);
    endfunction

    function bit event_complete(int e);
      logic [4:0] c;
      logic [4:0] f;
      c = cnt_tab[e];
      f = full_tab[e];
      if (c == COUNT_UNKNOWN) return 0;
      if (c == COUNT_ONE) return f[3];
      if (c == COUNT_TWO) return f[3] && f[4];
      return 1;
    endfunction

    // note one accepted input beat
    function void note_input(logic [1:0] mode, logic [31:0] key, logic [2:0] typ,
                             logic [3:0] cnt, logic [15:0] h, logic [9:0] sel);
      int e, s;
      bit found;
      if (mode == MODE_UNUSED) return;
      if (mode != MODE_RECORD) begin
        if (!in_use[sel]) push(ST_NOT_HELD, sel, 0, 0, 0);
        else begin
          emit_held(sel, (mode == MODE_DISCARD) ? ST_DISCARDED : ST_DISTRIBUTED);
          release_entry(sel);
        end
        pending[$].final_item = 1;
        return;
      end
      found = 0;
      e = 0;
      for (int i = 0; i < RECT_ENTRIES; i++)
        if (in_use[i] && key_tab[i] == key) begin
          e = i;
          found = 1;
          break;
        end
      if (!found) begin
        if (free_q.size() == 0) begin
          push(ST_NO_FREE, 0, 0, 0, 0);
          pending[$].final_item = 1;
          return;
        end
        e = free_q.pop_front();
        in_use[e] = 1;
        key_tab[e] = key;
        full_tab[e] = 0;
        cnt_tab[e] = COUNT_UNKNOWN;
      end
      s = SLOTS;
      if (typ <= TYPE_CWD) begin
        if (!full_tab[e][typ]) s = typ;
      end else if (typ == TYPE_PATH) begin
        if (!full_tab[e][3]) s = 3;
        else if (!full_tab[e][4]) s = 4;
      end
      if (s >= SLOTS) begin
        emit_held(e, ST_REJECTED);
        release_entry(e);
      end else begin
        full_tab[e][s] = 1;
        hnd_tab[e][s] = h;
        if (typ == TYPE_SYSCALL) cnt_tab[e] = {1'b0, cnt};
        if (event_complete(e)) emit_held(e, ST_COMPLETE);
        else push(ST_HELD, e, s, h, 1);
      end
      pending[$].final_item = 1;
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status)
        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
      if (got.held_entry !== exp_r.held_entry)
        $display("%0t: held_entry exp %0d got %0d", $time, exp_r.held_entry,
                 got.held_entry);
      if (got.slot !== exp_r.slot)
        $display("%0t: slot exp %0d got %0d", $time, exp_r.slot, got.slot);
      if (got.handle_out !== exp_r.handle_out)
        $display("%0t: handle_out exp %h got %h", $time, exp_r.handle_out,
                 got.handle_out);
      if (got.handle_valid !== exp_r.handle_valid)
        $display("%0t: handle_valid exp %b got %b", $time, exp_r.handle_valid,
                 got.handle_valid);
      if (got.final_item !== exp_r.final_item)
        $display("%0t: final_item exp %b got %b", $time, exp_r.final_item,
                 got.final_item);
      if (got !== exp_r) errors++;
    endfunction
  endclass
endpackage

// ----- tb/sv/testbench.sv -----
// testbench top: drives records and commands, checks result beats
`timescale 1ns / 1ps
module testbench;
  import rect_pkg::*;
  import rect_tb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  rect_in_if  in_ch ();
  rect_out_if out_ch ();

  collation_scoreboard sb = new();
  bit   quiet = 0;
  int   long_hold = 0;
  logic [31:0] keys [8];
  int   rec_count = 0;

  record_event_collation_table i_dut (.clk(clk), .rst_n(rst_n),
                                      .in_ch(in_ch), .out_ch(out_ch));

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.mode = 0;
    in_ch.seq_num = 0;
    in_ch.rec_type = 0;
    in_ch.item_count = 0;
    in_ch.rec_handle = 0;
    in_ch.entry_sel = 0;
    out_ch.ready = 0;
  end

  // send one beat and note it at acceptance; valid stays up for the next beat
  task automatic send(logic [1:0] m, logic [31:0] k, logic [2:0] t, logic [3:0] c,
                      logic [15:0] h, logic [9:0] sel);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.mode <= m;
    in_ch.seq_num <= k;
    in_ch.rec_type <= t;
    in_ch.item_count <= c;
    in_ch.rec_handle <= h;
    in_ch.entry_sel <= sel;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(m, k, t, c, h, sel);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one well-formed event: syscall, optional execve and cwd, counted paths
  task automatic send_event(logic [31:0] k);
    logic [3:0] c;
    c = 4'($urandom_range(0, 3));
    send(MODE_RECORD, k, TYPE_SYSCALL, c, 16'($urandom), 10'd0);
    if ($urandom_range(0, 1) != 0)
      send(MODE_RECORD, k, TYPE_EXECVE, 4'd0, 16'($urandom), 10'd0);
    if ($urandom_range(0, 1) != 0)
      send(MODE_RECORD, k, TYPE_CWD, 4'd0, 16'($urandom), 10'd0);
    for (int p = 0; p < int'(c) && p < 2; p++)
      send(MODE_RECORD, k, TYPE_PATH, 4'($urandom), 16'($urandom), 10'd0);
  endtask

  // receiver with random stall bursts and one long hold-off
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (long_hold > 0) begin
        out_ch.ready <= 0;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 0;
        stall = $urandom_range(1, 17);
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.status, out_ch.held_entry, out_ch.slot,
                         out_ch.handle_out, out_ch.handle_valid, out_ch.final_item});
    end
  end

  // stimulus
  initial begin
    int e;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 8; i++) keys[i] = $urandom;
    keys[0] = 32'h0;
    keys[1] = 32'hFFFF_FFFF;
    // directed: full event with two paths, extreme fields
    send(MODE_RECORD, keys[1], TYPE_EXECVE, 4'hF, 16'hFFFF, 10'h3FF);
    send(MODE_RECORD, keys[1], TYPE_CWD, 4'd0, 16'h0000, 10'd0);
    send(MODE_RECORD, keys[1], TYPE_SYSCALL, 4'd2, 16'h1234, 10'd0);
    send(MODE_RECORD, keys[1], TYPE_PATH, 4'd0, 16'hAAAA, 10'd0);
    send(MODE_RECORD, keys[1], TYPE_PATH, 4'd0, 16'h5555, 10'd0);
    // completed entry gets another path record, which finds both path slots taken and flushes
    send(MODE_RECORD, keys[1], TYPE_PATH, 4'd0, 16'h7777, 10'd0);
    // count 0 completes at once, then distribute
    send(MODE_RECORD, keys[0], TYPE_SYSCALL, 4'd0, 16'h0001, 10'd0);
    send(MODE_DISTRIBUTE, 32'd0, 3'd0, 4'd0, 16'd0, 10'd1);
    // count 1 event and discard
    send(MODE_RECORD, 32'h55, TYPE_SYSCALL, 4'd1, 16'h0002, 10'd0);
    send(MODE_RECORD, 32'h55, TYPE_PATH, 4'd0, 16'h0003, 10'd0);
    send(MODE_DISCARD, 32'd0, 3'd0, 4'd0, 16'd0, 10'd2);
    // unknown types, count 9, unused mode, not held entries
    send(MODE_RECORD, 32'h66, 3'd4, 4'd0, 16'h0004, 10'd0);
    send(MODE_RECORD, 32'h67, 3'd7, 4'd0, 16'h0005, 10'd0);
    send(MODE_RECORD, 32'h68, TYPE_SYSCALL, 4'd9, 16'h0006, 10'd0);
    send(MODE_RECORD, 32'h68, TYPE_SYSCALL, 4'd15, 16'h0007, 10'd0);
    send(MODE_UNUSED, 32'h69, TYPE_SYSCALL, 4'd0, 16'h0008, 10'h155);
    send(MODE_DISCARD, 32'd0, 3'd0, 4'd0, 16'd0, 10'h3FF);
    send(MODE_DISTRIBUTE, 32'd0, 3'd0, 4'd0, 16'd0, 10'h2AA);
    // third path record to one key is rejected and flushes the two held paths
    send(MODE_RECORD, 32'h70, TYPE_PATH, 4'd0, 16'h0009, 10'd0);
    send(MODE_RECORD, 32'h70, TYPE_PATH, 4'd0, 16'h000A, 10'd0);
    send(MODE_RECORD, 32'h70, TYPE_PATH, 4'd0, 16'h000B, 10'd0);
    drain();
    // long receiver hold-off while input keeps coming
    long_hold = 300;
    for (int i = 0; i < 10; i++) send_event(32'(keys[i % 8] + 32'(i)));
    drain();
    // random: mostly events on a few keys, some noise and commands
    while (rec_count < 180) begin
      case ($urandom_range(0, 9))
        0: send(2'($urandom_range(1, 2)), 32'd0, 3'd0, 4'd0, 16'd0,
                10'($urandom_range(0, 15)));
        1: send(MODE_RECORD, keys[$urandom_range(0, 7)], 3'($urandom_range(0, 7)),
                4'($urandom), 16'($urandom), 10'($urandom));
        2: send(2'($urandom), $urandom, 3'($urandom), 4'($urandom), 16'($urandom),
                10'($urandom));
        default: send_event(keys[$urandom_range(0, 7)] ^ $urandom_range(0, 3));
      endcase
      rec_count += 3;
      // free entries so the scan stays short
      if (sb.free_count() < RECT_ENTRIES - 12) begin
        e = $urandom_range(0, 15);
        send(MODE_DISCARD, 32'd0, 3'd0, 4'd0, 16'd0, 10'(e));
      end
      if (rec_count == 90) drain();
      if (rec_count > 150) quiet = 1;
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
